// ----- rtl/lcdw_pkg.sv -----
`default_nettype none
package lcdw_pkg;

  // Sequencer phases.
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_PWR        = 4'd1;
  localparam logic [3:0] PH_STROBE_E   = 4'd2;
  localparam logic [3:0] PH_STROBE_GAP = 4'd3;
  localparam logic [3:0] PH_HI_E       = 4'd4;
  localparam logic [3:0] PH_MID        = 4'd5;
  localparam logic [3:0] PH_LO_E       = 4'd6;
  localparam logic [3:0] PH_BYTE_WAIT  = 4'd7;
  localparam logic [3:0] PH_MS_WAIT    = 4'd8;

  // Request codes.
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_DATA   = 3'd1;
  localparam logic [2:0] CMD_CMD    = 3'd2;
  localparam logic [2:0] CMD_INIT   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_HOME   = 3'd5;
  localparam logic [2:0] CMD_CURSOR = 3'd6;

  // Init steps that select the next byte of the power-up sequence.
  localparam logic [3:0] STEP_NONE     = 4'd0;
  localparam logic [3:0] STEP_PWR      = 4'd1;
  localparam logic [3:0] STEP_FIRST    = 4'd2;
  localparam logic [3:0] STEP_SECOND   = 4'd3;
  localparam logic [3:0] STEP_FOUR_BIT = 4'd5;
  localparam logic [3:0] STEP_FUNC     = 4'd6;
  localparam logic [3:0] STEP_DISP     = 4'd7;
  localparam logic [3:0] STEP_ENTRY    = 4'd8;
  localparam logic [3:0] STEP_CLEAR    = 4'd9;

  // Controller bytes and nibbles.
  localparam logic [7:0] BYTE_FUNC_SET = 8'h28;
  localparam logic [7:0] BYTE_DISP_ON  = 8'h0C;
  localparam logic [7:0] BYTE_ENTRY    = 8'h06;
  localparam logic [7:0] BYTE_CLEAR    = 8'h01;
  localparam logic [7:0] BYTE_HOME     = 8'h02;
  localparam logic [7:0] BYTE_DDRAM    = 8'h80;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

  // Delays in microseconds.
  localparam logic [14:0] US_ZERO   = 15'd0;
  localparam logic [14:0] US_STROBE = 15'd1;
  localparam logic [14:0] US_BYTE   = 15'd42;
  localparam logic [14:0] US_1MS    = 15'd1000;
  localparam logic [14:0] US_5MS    = 15'd5000;
  localparam logic [14:0] US_PWR    = 15'd30000;

  localparam logic [7:0] TICKS_RESET = 8'd16;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  init_step;
    logic [7:0]  us_prescale;
    logic [14:0] us_remaining;
    logic [7:0]  byte_latch;
    logic        rs_level;
    logic        en_level;
    logic [3:0]  nibble_out;
    logic        after_wait_ms;
  } state_t;

  typedef struct packed {
    logic       rejected;
    logic       busy_res;
    logic [3:0] data_nibble;
    logic       en_pin;
    logic       rs_pin;
  } res_t;

  // DDRAM offset of rows 1 to 4, indexed by row minus one.
  function automatic logic [7:0] row_offset(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h00;
      2'd1: r = 8'h40;
      2'd2: r = 8'h10;
      2'd3: r = 8'h50;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/char_lcd_4bit_write_sequencer_top.sv -----
`default_nettype none
// Channel   Dir   Handshake                      Payload
// s_axis    in    s_axis_tvalid/s_axis_tready    tick request: cmd, value, column, row
// m_axis    out   m_axis_tvalid/m_axis_tready    pin levels and status after the tick
// apb       in    psel/penable/pwrite, pready    ticks_per_us at byte address 0
//
// Each accepted request is one timer tick and one state register update, and yields
// one registered result; a request can be taken in every cycle without an output stall.
// The result register frees when its result is taken, so input and output move
// together at one item per cycle; a stalled output holds the input off.
// Reset (synchronous, active high) puts the sequencer in idle with its pin levels low.
module char_lcd_4bit_write_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] cmd, [10:3] value, [14:11] column, [17:15] row, [23:18] zero
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] rs_pin, [1] en_pin, [5:2] data_nibble, [6] busy_res, [7] rejected
  output logic [7:0]       m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lcdw_pkg::*;

  logic [7:0] ticks_per_us;
  state_t     st;
  state_t     st_next;
  res_t       res_next;
  res_t       res;
  logic       in_take;

  lcdw_apb u_apb (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .ticks_per_us (ticks_per_us)
  );

  lcdw_step u_step (
    .st           (st),
    .cmd          (s_axis_tdata[2:0]),
    .value        (s_axis_tdata[10:3]),
    .column       (s_axis_tdata[14:11]),
    .row          (s_axis_tdata[17:15]),
    .ticks_per_us (ticks_per_us),
    .st_next      (st_next),
    .res          (res_next)
  );

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_take) begin
        st            <= st_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = res;
endmodule
`default_nettype wire

// ----- rtl/lcdw_apb.sv -----
`default_nettype none
module lcdw_apb (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [7:0]       ticks_per_us
);
  import lcdw_pkg::*;

  logic wr_ticks;

  assign pready   = 1'b1;
  // Only the word at address zero holds a register.
  assign wr_ticks = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= TICKS_RESET;
    end else if (wr_ticks) begin
      ticks_per_us <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'b0) begin
      prdata = {24'd0, ticks_per_us};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/lcdw_step.sv -----
`default_nettype none
module lcdw_step (
  input  lcdw_pkg::state_t st,
  input  wire logic [2:0]  cmd,
  input  wire logic [7:0]  value,
  input  wire logic [3:0]  column,
  input  wire logic [2:0]  row,
  input  wire logic [7:0]  ticks_per_us,
  output lcdw_pkg::state_t st_next,
  output lcdw_pkg::res_t   res
);
  import lcdw_pkg::*;

  function automatic state_t enter(input state_t s, input logic [3:0] ph,
                                   input logic [14:0] us);
    state_t r;
    r = s;
    r.phase        = ph;
    r.us_remaining = us;
    r.us_prescale  = '0;
    return r;
  endfunction

  function automatic state_t start_byte(input state_t s, input logic rs,
                                        input logic [7:0] b, input logic ms);
    state_t r;
    r = s;
    r.byte_latch    = b;
    r.after_wait_ms = ms;
    r.rs_level      = rs;
    r.nibble_out    = b[7:4];
    r.en_level      = 1'b1;
    return enter(r, PH_HI_E, US_STROBE);
  endfunction

  // After a byte, the power-up sequence chains its next byte or the block goes idle.
  function automatic state_t finish_byte(input state_t s);
    state_t r;
    r = s;
    if (s.init_step == STEP_FUNC) begin
      r.init_step = STEP_DISP;
      r = start_byte(r, 1'b0, BYTE_DISP_ON, 1'b0);
    end else if (s.init_step == STEP_DISP) begin
      r.init_step = STEP_ENTRY;
      r = start_byte(r, 1'b0, BYTE_ENTRY, 1'b0);
    end else if (s.init_step == STEP_ENTRY) begin
      r.init_step = STEP_CLEAR;
      r = start_byte(r, 1'b0, BYTE_CLEAR, 1'b1);
    end else begin
      r.init_step = STEP_NONE;
      r = enter(r, PH_IDLE, US_ZERO);
    end
    return r;
  endfunction

  function automatic state_t advance(input state_t s);
    state_t     r;
    logic [3:0] step_inc;
    r = s;
    step_inc = s.init_step + 4'd1;
    unique case (s.phase)
      PH_PWR: begin
        r.init_step  = STEP_FIRST;
        r.rs_level   = 1'b0;
        r.nibble_out = NIB_WAKE;
        r.en_level   = 1'b1;
        r = enter(r, PH_STROBE_E, US_STROBE);
      end
      PH_STROBE_E: begin
        r.en_level = 1'b0;
        r = enter(r, PH_STROBE_GAP, (s.init_step == STEP_FIRST) ? US_5MS : US_1MS);
      end
      PH_STROBE_GAP: begin
        r.init_step = step_inc;
        if (step_inc >= STEP_SECOND && step_inc <= STEP_FOUR_BIT) begin
          r.nibble_out = (step_inc == STEP_FOUR_BIT) ? NIB_FOUR_BIT : NIB_WAKE;
          r.en_level   = 1'b1;
          r = enter(r, PH_STROBE_E, US_STROBE);
        end else begin
          r.init_step = STEP_FUNC;
          r = start_byte(r, 1'b0, BYTE_FUNC_SET, 1'b0);
        end
      end
      PH_HI_E: begin
        r.en_level = 1'b0;
        r = enter(r, PH_MID, US_ZERO);
      end
      PH_MID: begin
        r.nibble_out = s.byte_latch[3:0];
        r.en_level   = 1'b1;
        r = enter(r, PH_LO_E, US_STROBE);
      end
      PH_LO_E: begin
        r.en_level = 1'b0;
        r = enter(r, PH_BYTE_WAIT, US_BYTE);
      end
      PH_BYTE_WAIT: begin
        if (s.after_wait_ms) begin
          r.after_wait_ms = 1'b0;
          r = enter(r, PH_MS_WAIT, US_5MS);
        end else begin
          r = finish_byte(r);
        end
      end
      PH_MS_WAIT: begin
        r = finish_byte(r);
      end
      default: begin
        r.init_step = STEP_NONE;
        r = enter(r, PH_IDLE, US_ZERO);
      end
    endcase
    return r;
  endfunction

  function automatic state_t tick_timer(input state_t s, input logic [7:0] tpu);
    state_t     r;
    logic [8:0] tp;
    logic [8:0] ps1;
    r   = s;
    // A rate of zero counts as one tick per microsecond.
    tp  = (tpu == 8'd0) ? 9'd1 : {1'b0, tpu};
    ps1 = {1'b0, s.us_prescale} + 9'd1;
    if (s.us_remaining == US_ZERO) begin
      r = advance(s);
    end else if (ps1 >= tp) begin
      r.us_prescale = '0;
      if (s.us_remaining <= US_STROBE) begin
        r.us_remaining = US_ZERO;
        r = advance(r);
      end else begin
        r.us_remaining = s.us_remaining - 15'd1;
      end
    end else begin
      r.us_prescale = ps1[7:0];
    end
    return r;
  endfunction

  logic       rej;
  logic [1:0] row_idx;
  logic [7:0] cursor_byte;
  logic       row_ok;

  assign row_idx     = 2'(row - 3'd1);
  assign row_ok      = (row >= 3'd1) && (row <= 3'd4);
  assign cursor_byte = BYTE_DDRAM + row_offset(row_idx) + {4'd0, column};

  always_comb begin
    st_next = st;
    rej     = 1'b0;
    if (st.phase != PH_IDLE) begin
      rej     = (cmd >= CMD_DATA) && (cmd <= CMD_CURSOR);
      st_next = tick_timer(st, ticks_per_us);
    end else begin
      unique case (cmd)
        CMD_DATA:  st_next = start_byte(st, 1'b1, value, 1'b0);
        CMD_CMD:   st_next = start_byte(st, 1'b0, value, 1'b0);
        CMD_INIT: begin
          st_next               = st;
          st_next.init_step     = STEP_PWR;
          st_next.after_wait_ms = 1'b0;
          st_next               = enter(st_next, PH_PWR, US_PWR);
        end
        CMD_CLEAR: st_next = start_byte(st, 1'b0, BYTE_CLEAR, 1'b1);
        CMD_HOME:  st_next = start_byte(st, 1'b0, BYTE_HOME, 1'b1);
        CMD_CURSOR: begin
          if (row_ok) begin
            st_next = start_byte(st, 1'b0, cursor_byte, 1'b0);
          end else begin
            rej = 1'b1;
          end
        end
        default: st_next = st;
      endcase
    end
  end

  always_comb begin
    res.rs_pin      = st_next.rs_level;
    res.en_pin      = st_next.en_level;
    res.data_nibble = st_next.nibble_out;
    res.busy_res    = st_next.phase != PH_IDLE;
    res.rejected    = rej;
  end
endmodule
`default_nettype wire
